@@ sv/pnlr_pkg.sv @@
// shared types, codes and small functions of the piano note LED renderer
package pnlr_pkg;

    // input command codes
    localparam logic [2:0] CMD_NOTE_ON   = 3'd0;
    localparam logic [2:0] CMD_NOTE_OFF  = 3'd1;
    localparam logic [2:0] CMD_SUSTAIN   = 3'd2;
    localparam logic [2:0] CMD_TICK      = 3'd3;
    localparam logic [2:0] CMD_TEST_STEP = 3'd4;
    localparam logic [2:0] CMD_READ_LED  = 3'd5;
    localparam logic [2:0] CMD_SPARE_6   = 3'd6;
    localparam logic [2:0] CMD_SPARE_7   = 3'd7;

    // configuration register byte addresses
    localparam logic [2:0] ADDR_MODE = 3'd0;
    localparam logic [2:0] ADDR_PEAK = 3'd4;

    // effect mode numbers
    localparam logic [7:0] MODE_TEST      = 8'd0;
    localparam logic [7:0] MODE_PLAIN_LO  = 8'd1;
    localparam logic [7:0] MODE_PLAIN_HI  = 8'd7;
    localparam logic [7:0] MODE_DECAY_LO  = 8'd8;
    localparam logic [7:0] MODE_DECAY_HI  = 8'd14;
    localparam logic [7:0] MODE_SPLIT     = 8'd50;
    localparam logic [7:0] MODE_ALTERNATE = 8'd51;
    localparam logic [7:0] MODE_EXPR      = 8'd52;

    localparam logic [7:0] DECAY_KNEE   = 8'd100;
    localparam logic [7:0] DECAY_DOUBLE = 8'd200;
    localparam logic [7:0] FULL_LEVEL   = 8'd255;
    localparam logic [2:0] TEST_LAST    = 3'd6;

    // kinds of full-store sweep
    typedef enum logic [2:0] {
        SW_SUS,
        SW_FILL,
        SW_DECAY,
        SW_ANY,
        SW_BG
    } sweep_kind_t;

    // controller to datapath commands
    typedef struct packed {
        logic        capture;
        logic        sus_set;
        logic        tci_step;
        logic        sweep_start;
        sweep_kind_t kind;
        logic        note_rd;
        logic        note_mul;
        logic        note_wr;
        logic        off;
        logic        sweep_rd;
        logic        sweep_wr;
        logic        out_ld;
    } pnlr_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [2:0] cmd;
        logic       note_ok;
        logic       pedal_zero;
        logic       sus_mode;
        logic       mode_fill;
        logic       mode_decay;
        logic       mode_bg;
        logic       kind_any;
        logic       idx_last;
        logic       out_free;
    } pnlr_stat_t;

    // floor(x / 255) for x below 65025
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    // one decay step of a channel
    function automatic logic [7:0] decay(input logic [7:0] x);
        logic [7:0] r;
        if (x > DECAY_KNEE)
            r = (x >= DECAY_DOUBLE) ? x - 8'd2 : x - 8'd1;
        else if (x != 8'd0)
            r = x - 8'd1;
        else
            r = 8'd0;
        return r;
    endfunction

    // test colors as {red, green, blue}; stray index shows red
    function automatic logic [23:0] test_color(input logic [2:0] i);
        logic [23:0] c;
        case (i)
            3'd1: c = 24'h00FF00;
            3'd2: c = 24'h0000FF;
            3'd3: c = 24'hFFFF00;
            3'd4: c = 24'hFF00FF;
            3'd5: c = 24'h00FFFF;
            3'd6: c = 24'hFFFFFF;
            default: c = 24'hFF0000;
        endcase
        return c;
    endfunction

    // channel enables for modes 1..7: bit0 red, bit1 green, bit2 blue
    function automatic logic [2:0] mode_channels(input logic [2:0] m);
        logic [2:0] c;
        case (m)
            3'd1: c = 3'b001;
            3'd2: c = 3'b010;
            3'd3: c = 3'b100;
            3'd4: c = 3'b011;
            3'd5: c = 3'b110;
            3'd6: c = 3'b101;
            3'd7: c = 3'b111;
            default: c = 3'b000;
        endcase
        return c;
    endfunction

endpackage

@@ sv/pnlr_ram.sv @@
// generic single write port, single read port RAM with registered read
module pnlr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 88,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

@@ sv/pnlr_ctrl.sv @@
// controller state machine of the piano note LED renderer
module pnlr_ctrl
    import pnlr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  pnlr_stat_t st,
    output pnlr_cmd_t  c
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_NOTE_RD,
        S_NOTE_MUL,
        S_NOTE_WR,
        S_OFF,
        S_SW_RD,
        S_SW_WR,
        S_OUT_RD,
        S_OUT_LD
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        c          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    c.capture  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_OUT_RD;
                case (st.cmd)
                    CMD_NOTE_ON:
                    begin
                        if (st.note_ok)
                            state_next = S_NOTE_RD;
                    end
                    CMD_NOTE_OFF:
                    begin
                        if (st.note_ok)
                            state_next = S_OFF;
                    end
                    CMD_SUSTAIN:
                    begin
                        c.sus_set = 1'b1;
                        if (st.pedal_zero && st.sus_mode)
                        begin
                            c.sweep_start = 1'b1;
                            c.kind        = SW_SUS;
                            state_next    = S_SW_RD;
                        end
                    end
                    CMD_TICK:
                    begin
                        if (st.mode_fill || st.mode_decay || st.mode_bg)
                        begin
                            c.sweep_start = 1'b1;
                            state_next    = S_SW_RD;
                            if (st.mode_fill)
                                c.kind = SW_FILL;
                            else if (st.mode_decay)
                                c.kind = SW_DECAY;
                            else
                                c.kind = SW_ANY;
                        end
                    end
                    CMD_TEST_STEP:
                    begin
                        c.tci_step = 1'b1;
                    end
                    default:
                    begin
                        state_next = S_OUT_RD;
                    end
                endcase
            end
            S_NOTE_RD:
            begin
                c.note_rd  = 1'b1;
                state_next = S_NOTE_MUL;
            end
            S_NOTE_MUL:
            begin
                c.note_mul = 1'b1;
                state_next = S_NOTE_WR;
            end
            S_NOTE_WR:
            begin
                c.note_wr  = 1'b1;
                state_next = S_OUT_RD;
            end
            S_OFF:
            begin
                c.off      = 1'b1;
                state_next = S_OUT_RD;
            end
            S_SW_RD:
            begin
                c.sweep_rd = 1'b1;
                state_next = S_SW_WR;
            end
            S_SW_WR:
            begin
                c.sweep_wr = 1'b1;
                if (!st.idx_last)
                    state_next = S_SW_RD;
                else if (st.kind_any)
                begin
                    // background pass follows the key scan
                    c.sweep_start = 1'b1;
                    c.kind        = SW_BG;
                    state_next    = S_SW_RD;
                end
                else
                    state_next = S_OUT_RD;
            end
            S_OUT_RD:
            begin
                state_next = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                if (st.out_free)
                begin
                    c.out_ld   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/pnlr_dp.sv @@
// datapath of the piano note LED renderer: stores, note scaling, sweeps, result register
module pnlr_dp
    import pnlr_pkg::*;
#(
    parameter int NUM_KEYS = 88
) (
    input  logic       clk,
    input  logic       rst_n,
    input  pnlr_cmd_t  c,
    output pnlr_stat_t st,
    input  logic [2:0] command,
    input  logic [6:0] note,
    input  logic [6:0] velocity,
    input  logic [6:0] pedal_level,
    input  logic [6:0] expression,
    input  logic [7:0] effect_mode,
    input  logic [7:0] peak_level,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] led_red,
    output logic [7:0] led_green,
    output logic [7:0] led_blue
);

    localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int VD = 2 ** AW;

    // key number to LED index
    function automatic logic [AW-1:0] led_of(input logic [6:0] k);
        logic [7:0] h;
        logic [7:0] r;
        h = {2'b00, k[6:1]};
        r = k[0] ? (8'(NUM_KEYS - 1) - h) : h;
        return r[AW-1:0];
    endfunction

    logic [2:0]  cmd_reg;
    logic [6:0]  note_reg, vel_reg, pedal_reg, expr_reg;
    logic [6:0]  sustain_reg;
    logic        alt_reg;
    logic [2:0]  tci_reg;
    logic        any_reg;
    sweep_kind_t kind_reg;
    logic [AW-1:0] idx_reg;
    logic [VD-1:0] vel_vld_reg, led_vld_reg;
    logic        vel_vq_reg, led_vq_reg;
    logic [15:0] pr_reg, pg_reg, pb_reg;
    logic [23:0] old_reg;
    logic        out_valid_reg;
    logic [23:0] out_reg;

    logic          vel_we, led_we;
    logic [AW-1:0] vel_waddr, led_waddr, led_raddr;
    logic [6:0]    vel_wdata, vel_rdata, vel_eff;
    logic [23:0]   led_wdata, led_rdata, led_eff;

    logic          note_ok;
    logic [AW-1:0] key_led, out_addr, idx_led;
    logic          m_plain, m_decay, m_sus, m_fill, m_bg;
    logic          dark, r_en, g_en, b_en;
    logic [2:0]    ch;
    logic [7:0]    new_r, new_g, new_b;
    logic [7:0]    bg_red;

    // mode classes
    always_comb
    begin
        m_plain = effect_mode inside {[MODE_PLAIN_LO:MODE_PLAIN_HI]};
        m_decay = effect_mode inside {[MODE_DECAY_LO:MODE_DECAY_HI]};
        m_sus   = m_decay || (effect_mode == MODE_SPLIT) || (effect_mode == MODE_ALTERNATE);
        m_fill  = (effect_mode == MODE_TEST);
        m_bg    = (effect_mode == MODE_EXPR);
    end

    assign note_ok  = ({1'b0, note_reg} < 8'(NUM_KEYS));
    assign key_led  = led_of(note_reg);
    assign idx_led  = led_of(7'(idx_reg));
    assign out_addr = (cmd_reg <= CMD_NOTE_OFF) ? key_led : note_reg[AW-1:0];
    assign vel_eff  = vel_vq_reg ? vel_rdata : 7'd0;
    assign led_eff  = led_vq_reg ? led_rdata : 24'd0;
    assign bg_red   = any_reg ? {1'b0, expr_reg} : 8'd0;

    // status to controller
    always_comb
    begin
        st.cmd        = cmd_reg;
        st.note_ok    = note_ok;
        st.pedal_zero = (pedal_reg == 7'd0);
        st.sus_mode   = m_sus;
        st.mode_fill  = m_fill;
        st.mode_decay = m_decay;
        st.mode_bg    = m_bg;
        st.kind_any   = (kind_reg == SW_ANY);
        st.idx_last   = (idx_reg == AW'(NUM_KEYS - 1));
        st.out_free   = !out_valid_reg || out_ready;
    end

    // channel enables for a note-on, from the mode and the LED as it stands
    always_comb
    begin
        dark = (led_eff[23:16] == 8'd0) && (led_eff[7:0] == 8'd0);
        ch   = 3'b000;
        if (m_plain)
            ch = mode_channels(effect_mode[2:0]);
        else if (m_decay)
            ch = mode_channels(3'(effect_mode - 8'd7));
        else if (m_bg)
            ch = 3'b100;
        else if (effect_mode == MODE_SPLIT)
            ch = note_reg[0] ? 3'b100 : 3'b001;
        else if (effect_mode == MODE_ALTERNATE)
        begin
            if (dark)
                ch = alt_reg ? 3'b100 : 3'b001;
            else
                ch = (led_eff[23:16] != 8'd0) ? 3'b001 : 3'b100;
        end
        r_en = ch[0];
        g_en = ch[1];
        b_en = ch[2];
    end

    // raise only upward
    always_comb
    begin
        new_r = div255(pr_reg);
        new_g = div255(pg_reg);
        new_b = div255(pb_reg);
        if (old_reg[23:16] > new_r)
            new_r = old_reg[23:16];
        if (old_reg[15:8] > new_g)
            new_g = old_reg[15:8];
        if (old_reg[7:0] > new_b)
            new_b = old_reg[7:0];
    end

    // velocity store port control
    always_comb
    begin
        vel_we    = 1'b0;
        vel_waddr = note_reg[AW-1:0];
        vel_wdata = 7'd0;
        if (c.note_rd)
        begin
            vel_we    = 1'b1;
            vel_wdata = vel_reg;
        end
        else if (c.off)
            vel_we = 1'b1;
    end

    // LED store port control
    always_comb
    begin
        led_we    = 1'b0;
        led_waddr = key_led;
        led_wdata = 24'd0;
        if (c.note_rd)
            led_raddr = key_led;
        else if (c.sweep_rd)
            led_raddr = idx_reg;
        else
            led_raddr = out_addr;
        if (c.note_wr)
        begin
            led_we    = 1'b1;
            led_wdata = {new_r, new_g, new_b};
        end
        else if (c.off)
            led_we = m_plain || (m_sus && (sustain_reg == 7'd0));
        else if (c.sweep_wr)
        begin
            case (kind_reg)
                SW_SUS:
                begin
                    led_we    = (vel_eff == 7'd0);
                    led_waddr = idx_led;
                end
                SW_FILL:
                begin
                    led_we    = 1'b1;
                    led_waddr = idx_reg;
                    led_wdata = test_color(tci_reg);
                end
                SW_DECAY:
                begin
                    led_we    = 1'b1;
                    led_waddr = idx_reg;
                    led_wdata = {decay(led_eff[23:16]), decay(led_eff[15:8]),
                                 decay(led_eff[7:0])};
                end
                SW_BG:
                begin
                    led_we    = (vel_eff == 7'd0);
                    led_waddr = idx_led;
                    led_wdata = {bg_red, 16'd0};
                end
                default:
                begin
                    led_we = 1'b0;
                end
            endcase
        end
    end

    pnlr_ram #(.WIDTH(7), .DEPTH(NUM_KEYS)) u_vel_ram (
        .clk   (clk),
        .we    (vel_we),
        .waddr (vel_waddr),
        .wdata (vel_wdata),
        .raddr (idx_reg),
        .rdata (vel_rdata)
    );

    pnlr_ram #(.WIDTH(24), .DEPTH(NUM_KEYS)) u_led_ram (
        .clk   (clk),
        .we    (led_we),
        .waddr (led_waddr),
        .wdata (led_wdata),
        .raddr (led_raddr),
        .rdata (led_rdata)
    );

    // item capture, note scaling products and result register
    always_ff @(posedge clk)
    begin
        if (c.capture)
        begin
            cmd_reg   <= command;
            note_reg  <= note;
            vel_reg   <= velocity;
            pedal_reg <= pedal_level;
            expr_reg  <= expression;
        end
        if (c.note_mul)
        begin
            pr_reg  <= 16'({vel_reg, 1'b0}) * 16'(r_en ? peak_level : 8'd0);
            pg_reg  <= 16'({vel_reg, 1'b0}) * 16'(g_en ? peak_level : 8'd0);
            pb_reg  <= 16'({vel_reg, 1'b0}) * 16'(b_en ? peak_level : 8'd0);
            old_reg <= led_eff;
        end
        if (c.out_ld && st.out_free)
            out_reg <= (note_ok && (cmd_reg <= CMD_READ_LED)) ? led_eff : 24'd0;
    end

    // control state, valid bits, sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sustain_reg   <= 7'd0;
            alt_reg       <= 1'b0;
            tci_reg       <= 3'd0;
            any_reg       <= 1'b0;
            kind_reg      <= SW_SUS;
            idx_reg       <= '0;
            vel_vld_reg   <= '0;
            led_vld_reg   <= '0;
            vel_vq_reg    <= 1'b0;
            led_vq_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vel_vq_reg <= vel_vld_reg[idx_reg];
            led_vq_reg <= led_vld_reg[led_raddr];
            if (vel_we)
                vel_vld_reg[vel_waddr] <= 1'b1;
            if (led_we)
                led_vld_reg[led_waddr] <= 1'b1;
            if (c.sus_set)
                sustain_reg <= pedal_reg;
            if (c.tci_step)
                tci_reg <= (tci_reg >= TEST_LAST) ? 3'd0 : tci_reg + 3'd1;
            if (c.note_mul && (effect_mode == MODE_ALTERNATE) && dark)
                alt_reg <= ~alt_reg;
            if (c.sweep_wr && (kind_reg == SW_ANY) && (vel_eff != 7'd0))
                any_reg <= 1'b1;
            if (c.sweep_start)
            begin
                idx_reg  <= '0;
                kind_reg <= c.kind;
                if (c.kind == SW_ANY)
                    any_reg <= 1'b0;
            end
            else if (c.sweep_wr)
                idx_reg <= idx_reg + AW'(1);
            if (c.out_ld && st.out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign led_red   = out_reg[23:16];
    assign led_green = out_reg[15:8];
    assign led_blue  = out_reg[7:0];

    // sweep restarts from the first entry
    assert property (@(posedge clk) disable iff (!rst_n)
        c.sweep_start |=> (idx_reg == '0))
        else $error("sweep counter not cleared at sweep start");

    // a result load always presents a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (c.out_ld && st.out_free) |=> out_valid_reg)
        else $error("result load lost");

    // alternation only moves during note-on scaling
    assert property (@(posedge clk) disable iff (!rst_n)
        !c.note_mul |=> $stable(alt_reg))
        else $error("alternation changed outside note-on");

    // the sweep never runs past the last key
    assert property (@(posedge clk) disable iff (!rst_n)
        c.sweep_wr |-> (idx_reg <= AW'(NUM_KEYS - 1)))
        else $error("sweep index beyond last key");

endmodule

@@ sv/piano_note_led_renderer.sv @@
// Piano note LED renderer top level: configuration registers, controller and datapath.
// Takes one event at a time and returns one RGB result per event. A note-on passes the
// read, scaling and write states before the result read and load; a note-off passes the
// clear state, and a read, test step, unused command, quiet tick or note out of range goes
// straight to the result read and load. A sustain release, a test fill or a decay tick
// walks every key, reading the LED and velocity memories and writing the LED memory key
// by key, and the expression background tick walks twice. The next event is taken in the
// cycle after the result is loaded, and a result still waiting in the output register
// holds the following event just before its load. Stores read as zero after reset
// through per-entry valid bits, so no clearing pass is needed.
// Registers: effect_mode at byte address 0, peak channel level at 4.
module piano_note_led_renderer
    import pnlr_pkg::*;
#(
    parameter int NUM_KEYS = 88
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [6:0]  note,
    input  logic [6:0]  velocity,
    input  logic [6:0]  pedal_level,
    input  logic [6:0]  expression,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  led_red,
    output logic [7:0]  led_green,
    output logic [7:0]  led_blue,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] mode_reg, max_reg;
    pnlr_cmd_t  cmd;
    pnlr_stat_t stat;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 8'd0;
            max_reg  <= FULL_LEVEL;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == ADDR_MODE[2])
                mode_reg <= pwdata[7:0];
            else
                max_reg <= pwdata[7:0];
        end
    end

    // configuration readback
    assign pready = 1'b1;
    assign prdata = {24'd0, (paddr[2] == ADDR_MODE[2]) ? mode_reg : max_reg};

    pnlr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (stat),
        .c        (cmd)
    );

    pnlr_dp #(.NUM_KEYS(NUM_KEYS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .c             (cmd),
        .st            (stat),
        .command       (command),
        .note          (note),
        .velocity      (velocity),
        .pedal_level   (pedal_level),
        .expression    (expression),
        .effect_mode   (mode_reg),
        .peak_level    (max_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .led_red       (led_red),
        .led_green     (led_green),
        .led_blue      (led_blue)
    );

endmodule
